// File: hdl/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg: shared types and constants of the infix expression evaluator
// operator codes, status codes, stack geometry and sequencer states
// ----------------------------------------------------------------------------
package iee_pkg;

	localparam int ValueDepth = 32;
	localparam int OperatorDepth = 32;
	localparam int VAW = $clog2(ValueDepth);
	localparam int OAW = $clog2(OperatorDepth);
	localparam int VCW = $clog2(ValueDepth + 1);
	localparam int OCW = $clog2(OperatorDepth + 1);

	typedef enum logic [2:0] {
		OP_LPAR = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_MALF  = 2'd1,
		ST_DIV0  = 2'd2,
		ST_OVFL  = 2'd3
	} status_t;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_ADD   = 8'h2B;
	localparam logic [7:0] CH_SUB   = 8'h2D;
	localparam logic [7:0] CH_DIV   = 8'h2F;

	typedef enum logic [3:0] {
		S_IDLE,    // waiting for a character
		S_DECIDE,  // top-of-stack reads are valid
		S_RDVAL,   // value reads in flight
		S_OPND,    // operands valid, start arithmetic
		S_MULW,    // multiply partial products
		S_DIVW,    // divider running
		S_WBACK,   // write result
		S_DIGIT,   // digit accumulate read done
		S_FINISH,  // present result
		S_OUT,     // result waiting in output register
		S_RELOAD   // re-read stack tops before the end drain
	} state_t;

	typedef struct packed {
		logic start;
		logic is_div;
		logic [63:0] a;
		logic [63:0] b;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic [63:0] r;
	} alu_rsp_t;

	function automatic logic [1:0] prec(input logic [2:0] op);
		case (op)
			OP_MUL, OP_DIV: prec = 2'd2;
			OP_ADD, OP_SUB: prec = 2'd1;
			default: prec = 2'd0;
		endcase
	endfunction

endpackage

// File: hdl/infix_expression_evaluator_core.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core: two-stack infix expression evaluator
// value and operator stacks in synchronous ram, one sequencer, shared alu
// ----------------------------------------------------------------------------
// characters arrive one beat at a time; digits build numbers, + - * / and
// parentheses drive a value stack and an operator stack held in two rams
// with registered reads. a plain character is decoded once the stack tops
// are read, and a digit that extends a number adds a read-modify-write of
// the top value; each reduction reads the stack tops, pops the operator and
// writes the result back, after the alu where needed: multiply uses 32x32
// partial products, divide takes one quotient bit per cycle. the beat with
// end_of_expression set has the stack tops re-read, reduces what is left and
// produces one result beat (value, status); the stacks are then emptied by
// resetting their counts. one character is in work at a time, and the input
// stalls while it is. the first error sticks until the end beat.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_core
	import iee_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  character,
	input  logic        end_of_expression,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [63:0] value,
	output logic [1:0]  status
);
	state_t state_q, state_d;

	logic [VCW-1:0] vcnt_q, vcnt_d;
	logic [OCW-1:0] ocnt_q, ocnt_d;
	logic           pdig_q, pdig_d;
	logic [1:0]     err_q, err_d;
	logic [7:0]     ch_q, ch_d;
	logic           last_q, last_d;
	logic [2:0]     op_q, op_d;      // operator being reduced
	logic [63:0]    b_q, b_d;        // top value during reduction
	logic [63:0]    res_q, res_d;    // reduction result
	logic [2:0]     pend_q, pend_d;  // operator waiting to push
	logic           final_q, final_d; // in end-of-expression drain

	// ram ports
	logic            v_we, o_we;
	logic [VAW-1:0]  v_waddr, v_raddr;
	logic [OAW-1:0]  o_waddr, o_raddr;
	logic [63:0]     v_wdata, v_rdata;
	logic [2:0]      o_wdata, o_rdata;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic        out_valid_q;
	logic [63:0] out_value_q;
	logic [1:0]  out_status_q;

	iee_ram #(.Width(64), .Depth(ValueDepth)) u_vstack (
		.clk, .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(v_raddr), .rdata(v_rdata)
	);
	iee_ram #(.Width(3), .Depth(OperatorDepth)) u_ostack (
		.clk, .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
		.raddr(o_raddr), .rdata(o_rdata)
	);
	iee_alu u_alu (.clk, .arst_n, .req(alu_req), .rsp(alu_rsp));

	// by default the read addresses track the stack tops
	logic [VCW-1:0] vtop1, vtop2;
	logic [OCW-1:0] otop1;
	assign vtop1 = vcnt_q - VCW'(1);
	assign vtop2 = vcnt_q - VCW'(2);
	assign otop1 = ocnt_q - OCW'(1);

	logic is_digit, is_opch;
	logic [2:0] ch_op;
	always_comb begin
		is_digit = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
		is_opch = 1'b1;
		case (ch_q)
			CH_ADD: ch_op = OP_ADD;
			CH_SUB: ch_op = OP_SUB;
			CH_MUL: ch_op = OP_MUL;
			CH_DIV: ch_op = OP_DIV;
			default: begin ch_op = OP_LPAR; is_opch = 1'b0; end
		endcase
	end

	logic [63:0] dig_acc;
	assign dig_acc = {v_rdata[60:0], 3'b000} + {v_rdata[62:0], 1'b0}
		+ {60'd0, ch_q[3:0] - 4'd0};

	logic [63:0] addsub;
	assign addsub = (op_q == OP_SUB) ? (v_rdata - b_q) : (v_rdata + b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vcnt_q <= '0;
			ocnt_q <= '0;
			pdig_q <= 1'b0;
			err_q <= ST_OK;
			final_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vcnt_q <= vcnt_d;
			ocnt_q <= ocnt_d;
			pdig_q <= pdig_d;
			err_q <= err_d;
			final_q <= final_d;
			if (state_q == S_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ch_q <= ch_d;
		last_q <= last_d;
		op_q <= op_d;
		b_q <= b_d;
		res_q <= res_d;
		pend_q <= pend_d;
		if (state_q == S_FINISH) begin
			out_value_q <= (err_q == ST_OK) ? v_rdata : 64'd0;
			out_status_q <= err_q;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign value = out_value_q;
	assign status = out_status_q;

	always_comb begin
		state_d = state_q;
		vcnt_d = vcnt_q;
		ocnt_d = ocnt_q;
		pdig_d = pdig_q;
		err_d = err_q;
		ch_d = ch_q;
		last_d = last_q;
		op_d = op_q;
		b_d = b_q;
		res_d = res_q;
		pend_d = pend_q;
		final_d = final_q;
		v_we = 1'b0;
		o_we = 1'b0;
		v_waddr = vtop1[VAW-1:0];
		v_wdata = res_q;
		o_waddr = ocnt_q[OAW-1:0];
		o_wdata = pend_q;
		v_raddr = vtop1[VAW-1:0];
		o_raddr = otop1[OAW-1:0];
		alu_req = '0;
		alu_req.a = v_rdata;
		alu_req.b = b_q;
		alu_req.is_div = (op_q == OP_DIV);

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ch_d = character;
					last_d = end_of_expression;
					final_d = 1'b0;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				// o_rdata is top operator, v_rdata top value
				if (final_q) begin
					if (err_q != ST_OK || ocnt_q == '0) begin
						if (err_q == ST_OK && vcnt_q != VCW'(1)) begin
							err_d = ST_MALF;
						end
						v_raddr = '0;
						state_d = S_FINISH;
					end else if (o_rdata == OP_LPAR) begin
						err_d = ST_MALF;
						v_raddr = '0;
						state_d = S_FINISH;
					end else begin
						state_d = S_RDVAL;
					end
				end else if (err_q != ST_OK) begin
					state_d = S_IDLE;
				end else if (is_digit) begin
					if (pdig_q && vcnt_q != '0) begin
						state_d = S_DIGIT;
					end else begin
						if (vcnt_q >= VCW'(ValueDepth)) begin
							err_d = ST_OVFL;
						end else begin
							v_we = 1'b1;
							v_waddr = vcnt_q[VAW-1:0];
							v_wdata = {60'd0, ch_q[3:0]};
							vcnt_d = vcnt_q + VCW'(1);
						end
						pdig_d = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					pdig_d = 1'b0;
					if (ch_q == CH_SPACE) begin
						state_d = S_IDLE;
					end else if (ch_q == CH_LPAR) begin
						pend_d = OP_LPAR;
						if (ocnt_q >= OCW'(OperatorDepth)) begin
							err_d = ST_OVFL;
						end else begin
							o_we = 1'b1;
							o_wdata = OP_LPAR;
							ocnt_d = ocnt_q + OCW'(1);
						end
						state_d = S_IDLE;
					end else if (ch_q == CH_RPAR) begin
						if (ocnt_q == '0) begin
							err_d = ST_MALF;
							state_d = S_IDLE;
						end else if (o_rdata == OP_LPAR) begin
							ocnt_d = otop1;
							state_d = S_IDLE;
						end else begin
							state_d = S_RDVAL;
						end
					end else if (is_opch) begin
						if (ocnt_q != '0 && o_rdata != OP_LPAR
							&& prec(ch_op) <= prec(o_rdata)) begin
							state_d = S_RDVAL;
						end else if (ocnt_q >= OCW'(OperatorDepth)) begin
							err_d = ST_OVFL;
							state_d = S_IDLE;
						end else begin
							o_we = 1'b1;
							o_wdata = ch_op;
							ocnt_d = ocnt_q + OCW'(1);
							state_d = S_IDLE;
						end
					end else begin
						err_d = ST_MALF;
						state_d = S_IDLE;
					end
				end
				// counts may have moved this cycle, so re-read the tops first
				if (last_q && !final_q && state_d == S_IDLE) begin
					final_d = 1'b1;
					state_d = S_RELOAD;
				end
			end
			S_RELOAD: begin
				state_d = S_DECIDE;
			end
			S_RDVAL: begin
				// pop operator, read top value now, second value next
				op_d = o_rdata;
				ocnt_d = otop1;
				b_d = v_rdata;
				v_raddr = vtop2[VAW-1:0];
				if (vcnt_q < VCW'(2)) begin
					err_d = ST_MALF;
					state_d = last_q ? S_DECIDE : S_IDLE;
					final_d = last_q;
				end else begin
					state_d = S_OPND;
				end
			end
			S_OPND: begin
				if (op_q == OP_ADD || op_q == OP_SUB) begin
					res_d = addsub;
					state_d = S_WBACK;
				end else if (op_q == OP_MUL) begin
					alu_req.start = 1'b1;
					state_d = S_MULW;
				end else if (op_q == OP_DIV) begin
					if (b_q == 64'd0) begin
						err_d = ST_DIV0;
						state_d = last_q ? S_DECIDE : S_IDLE;
						final_d = last_q;
					end else if (v_rdata == {1'b1, 63'd0} && b_q == '1) begin
						res_d = v_rdata;
						state_d = S_WBACK;
					end else begin
						alu_req.start = 1'b1;
						state_d = S_DIVW;
					end
				end else begin
					err_d = ST_MALF;
					state_d = last_q ? S_DECIDE : S_IDLE;
					final_d = last_q;
				end
			end
			S_MULW, S_DIVW: begin
				if (alu_rsp.done) begin
					res_d = alu_rsp.r;
					state_d = S_WBACK;
				end
			end
			S_WBACK: begin
				v_we = 1'b1;
				v_waddr = vtop2[VAW-1:0];
				v_wdata = res_q;
				vcnt_d = vtop1;
				// reread tops for the next loop check
				v_raddr = vtop2[VAW-1:0];
				o_raddr = otop1[OAW-1:0];
				state_d = S_DECIDE;
			end
			S_DIGIT: begin
				v_we = 1'b1;
				v_wdata = dig_acc;
				pdig_d = 1'b1;
				state_d = last_q ? S_DECIDE : S_IDLE;
				final_d = last_q;
			end
			S_FINISH: begin
				vcnt_d = '0;
				ocnt_d = '0;
				pdig_d = 1'b0;
				err_d = ST_OK;
				final_d = 1'b0;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// File: hdl/iee_ram.sv
// ----------------------------------------------------------------------------
// iee_ram: generic single-port-write, single-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module iee_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hdl/iee_alu.sv
// ----------------------------------------------------------------------------
// iee_alu: multi-cycle multiply and signed divide
// 32x32 partial products, restoring divide one bit per cycle
// ----------------------------------------------------------------------------
module iee_alu
	import iee_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);
	logic        busy_q;
	logic        done_q;
	logic        div_q;
	logic [6:0]  cnt_q;
	logic [63:0] a_q, b_q;
	logic [63:0] acc_q;
	logic [63:0] rem_q;
	logic        neg_q;
	logic [63:0] prod;
	logic [31:0] pa, pb;
	logic [64:0] trial;
	logic [63:0] rem_sh;
	logic [63:0] abs_a, abs_b;

	assign abs_a = req.a[63] ? (~req.a + 64'd1) : req.a;
	assign abs_b = req.b[63] ? (~req.b + 64'd1) : req.b;

	// partial product select: lo*lo, lo*hi, hi*lo
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin pa = a_q[31:0];  pb = b_q[31:0];  end
			2'd1: begin pa = a_q[31:0];  pb = b_q[63:32]; end
			default: begin pa = a_q[63:32]; pb = b_q[31:0]; end
		endcase
	end
	assign prod = {32'd0, pa} * {32'd0, pb};

	assign rem_sh = {rem_q[62:0], a_q[63]};
	assign trial = {1'b0, rem_sh} - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if ((div_q && cnt_q == 7'd63) || (!div_q && cnt_q == 7'd2)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			cnt_q <= 7'd0;
			acc_q <= 64'd0;
			rem_q <= 64'd0;
			neg_q <= req.a[63] ^ req.b[63];
			a_q <= req.is_div ? abs_a : req.a;
			b_q <= req.is_div ? abs_b : req.b;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 7'd1;
			if (div_q) begin
				a_q <= {a_q[62:0], 1'b0};
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					acc_q <= {acc_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					acc_q <= {acc_q[62:0], 1'b0};
				end
			end else if (cnt_q[1:0] == 2'd0) begin
				acc_q <= prod;
			end else begin
				acc_q <= acc_q + {prod[31:0], 32'd0};
			end
		end
	end

	// the final divide step lands in acc_q the same edge done rises
	assign rsp = '{done: done_q, r: ((div_q && neg_q) ? (~acc_q + 64'd1) : acc_q)};
endmodule

// File: hdl/iee_checker.sv
// ----------------------------------------------------------------------------
// iee_checker: port-level checks of the evaluator
// handshake holds and result sanity
// ----------------------------------------------------------------------------
module iee_checker
	import iee_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] value,
	input logic [1:0]  status
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
		else $error("result beat changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> value == 64'd0)
		else $error("error result carries a nonzero value");

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	a_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result beat repeated");
endmodule

bind infix_expression_evaluator_core iee_checker u_iee_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .value, .status
);
